/* src/wsfd_pkg.sv */
package wsfd_pkg;

  // Width of the payload length counter
  localparam int unsigned LengthBits = 64;

  // Result queue between parser and output stage
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  // Opcodes that produce results
  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;

  // Short length codes that announce an extended length
  localparam logic [6:0] LenExt16 = 7'd126;
  localparam logic [6:0] LenExt64 = 7'd127;

  // Extended length and mask key byte counts
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [3:0] KeyBytes   = 4'd4;

  typedef enum logic [2:0] {
    PhHdr0 = 3'd0,
    PhHdr1 = 3'd1,
    PhExt  = 3'd2,
    PhKey  = 3'd3,
    PhData = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KindText  = 2'd0,
    KindPing  = 2'd1,
    KindClose = 2'd2
  } kind_e;

  // One classified result travelling from parser to output stage
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       dvalid;
    kind_e      kind;
    logic       last;
  } res_t;

endpackage

/* src/wsfd_front.sv */
module wsfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  output logic              res_valid_o,
  output wsfd_pkg::res_t    res_o
);

  wsfd_pkg::phase_e                   phase_q, phase_d;
  logic [3:0]                         opcode_q, opcode_d;
  logic                               mask_q, mask_d;
  logic [3:0]                         hcount_q, hcount_d;
  logic [wsfd_pkg::LengthBits-1:0]    remain_q, remain_d;
  logic [31:0]                        key_q, key_d;
  logic [1:0]                         midx_q, midx_d;
  logic                               closed_q, closed_d;

  logic       len_done;
  logic       hdr_done;
  logic       fin;
  logic       last;
  logic       emits;
  logic [6:0] short_len;
  logic [7:0] key_byte;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsfd_pkg::PhHdr0;
      opcode_q <= '0;
      mask_q   <= 1'b0;
      hcount_q <= '0;
      remain_q <= '0;
      key_q    <= '0;
      midx_q   <= '0;
      closed_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      hcount_q <= hcount_d;
      remain_q <= remain_d;
      key_q    <= key_d;
      midx_q   <= midx_d;
      closed_q <= closed_d;
    end
  end

  // Key byte for the current payload position, first key byte at index 0
  always_comb begin
    unique case (midx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign emits     = (opcode_q == wsfd_pkg::OpText) || (opcode_q == wsfd_pkg::OpPing);
  assign short_len = rx_byte_i[6:0];
  assign last      = (remain_q == {{(wsfd_pkg::LengthBits-1){1'b0}}, 1'b1});

  // Header parse, length tracking and result classification
  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    mask_d      = mask_q;
    hcount_d    = hcount_q;
    remain_d    = remain_q;
    key_d       = key_q;
    midx_d      = midx_q;
    closed_d    = closed_q;
    len_done    = 1'b0;
    hdr_done    = 1'b0;
    fin         = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (accept_i && !closed_q) begin
      unique case (phase_q)
        wsfd_pkg::PhHdr1: begin
          mask_d   = rx_byte_i[7];
          remain_d = '0;
          if (short_len == wsfd_pkg::LenExt16 || short_len == wsfd_pkg::LenExt64) begin
            hcount_d = (short_len == wsfd_pkg::LenExt16) ? wsfd_pkg::ExtBytes16
                                                         : wsfd_pkg::ExtBytes64;
            phase_d  = wsfd_pkg::PhExt;
          end else begin
            remain_d = {{(wsfd_pkg::LengthBits-7){1'b0}}, short_len};
            len_done = 1'b1;
          end
        end
        wsfd_pkg::PhExt: begin
          // saturate once another byte would overflow the counter
          if (remain_q[wsfd_pkg::LengthBits-1 -: 8] != 8'd0) begin
            remain_d = '1;
          end else begin
            remain_d = {remain_q[wsfd_pkg::LengthBits-9:0], rx_byte_i};
          end
          hcount_d = hcount_q - 4'd1;
          if (hcount_d == 4'd0) begin
            len_done = 1'b1;
          end
        end
        wsfd_pkg::PhKey: begin
          key_d    = {key_q[23:0], rx_byte_i};
          hcount_d = hcount_q - 4'd1;
          if (hcount_d == 4'd0) begin
            hdr_done = 1'b1;
          end
        end
        wsfd_pkg::PhData: begin
          midx_d   = midx_q + 2'd1;
          remain_d = remain_q - {{(wsfd_pkg::LengthBits-1){1'b0}}, 1'b1};
          if (emits) begin
            res_valid_o  = 1'b1;
            res_o.data   = rx_byte_i;
            res_o.key    = mask_q ? key_byte : 8'd0;
            res_o.dvalid = 1'b1;
            res_o.kind   = (opcode_q == wsfd_pkg::OpPing) ? wsfd_pkg::KindPing
                                                          : wsfd_pkg::KindText;
            res_o.last   = last;
            if (last) begin
              phase_d = wsfd_pkg::PhHdr0;
            end
          end else if (last) begin
            fin = 1'b1;
          end
        end
        default: begin
          // first header byte, unused codes land here too
          opcode_d = rx_byte_i[3:0];
          phase_d  = wsfd_pkg::PhHdr1;
        end
      endcase

      // length complete: key bytes follow when masked
      if (len_done) begin
        if (mask_d) begin
          phase_d  = wsfd_pkg::PhKey;
          hcount_d = wsfd_pkg::KeyBytes;
        end else begin
          hdr_done = 1'b1;
        end
      end

      // header complete: payload or an empty frame
      if (hdr_done) begin
        midx_d = '0;
        if (remain_d == '0) begin
          fin = 1'b1;
        end else begin
          phase_d = wsfd_pkg::PhData;
        end
      end

      // frame end marker
      if (fin) begin
        phase_d = wsfd_pkg::PhHdr0;
        if (opcode_d == wsfd_pkg::OpClose) begin
          closed_d    = 1'b1;
          res_valid_o = 1'b1;
          res_o.kind  = wsfd_pkg::KindClose;
          res_o.last  = 1'b1;
        end else if (opcode_d == wsfd_pkg::OpText || opcode_d == wsfd_pkg::OpPing) begin
          res_valid_o = 1'b1;
          res_o.kind  = (opcode_d == wsfd_pkg::OpPing) ? wsfd_pkg::KindPing
                                                       : wsfd_pkg::KindText;
          res_o.last  = 1'b1;
        end
      end
    end
  end

endmodule

/* src/wsfd_queue.sv */
module wsfd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wsfd_pkg::res_t    push_item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output wsfd_pkg::res_t    head_o
);

  wsfd_pkg::res_t                    mem_q [wsfd_pkg::QueueDepth];
  logic [wsfd_pkg::QueuePtrW-1:0]    wptr_q, wptr_d;
  logic [wsfd_pkg::QueuePtrW-1:0]    rptr_q, rptr_d;
  logic [wsfd_pkg::QueueCntW-1:0]    count_q, count_d;
  logic                              do_push;
  logic                              do_pop;

  assign full_o  = (count_q == wsfd_pkg::QueueCntW'(wsfd_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  // Pointer and fill count update
  always_comb begin
    wptr_d  = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = do_pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Item storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

/* src/wsfd_back.sv */
module wsfd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  wsfd_pkg::res_t    item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        data_byte_o,
  output logic              data_valid_o,
  output logic [1:0]        frame_kind_o,
  output logic              frame_last_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       dvalid_q;
  logic [1:0] kind_q;
  logic       last_q;

  // Load a new item whenever the output register is free or draining
  assign pop_o   = avail_i && (!valid_q || !out_stall_i);
  assign valid_d = pop_o ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Output payload, unmasked on load
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q   <= item_i.data ^ item_i.key;
      dvalid_q <= item_i.dvalid;
      kind_q   <= 2'(item_i.kind);
      last_q   <= item_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign data_byte_o  = data_q;
  assign data_valid_o = dvalid_q;
  assign frame_kind_o = kind_q;
  assign frame_last_o = last_q;

endmodule

/* src/websocket_frame_deframer_core.sv */
// Path: each byte is classified combinationally, its result is written into the result
// queue at the edge that takes the byte and is then loaded into the output register.
// Throughput: one byte per cycle while in_stall_o is low; the parser never waits on itself.
// in_stall_o is high while the two-entry result queue is full, which only a stalled output
// causes; it falls at the first edge at which the output takes an item again.
// Reset (rst_ni low, asynchronous): parser returns to the first header byte, the stream
// is reopened after a close frame, and the queue and output register are emptied.
module websocket_frame_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       data_valid_o,
  output logic [1:0] frame_kind_o,
  output logic       frame_last_o
);

  logic           accept;
  logic           res_valid;
  wsfd_pkg::res_t res;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  wsfd_pkg::res_t q_head;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // Header parser and classifier
  wsfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Decoupling queue
  wsfd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_item_i(res),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  // Unmasking and output register
  wsfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (!q_empty),
    .item_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_byte_o (data_byte_o),
    .data_valid_o(data_valid_o),
    .frame_kind_o(frame_kind_o),
    .frame_last_o(frame_last_o)
  );

endmodule
